@@ rtl/core/ltlc_pkg.sv @@
package ltlc_pkg;

    localparam int ENTRIES   = 64;
    localparam int KEY_BITS  = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CFG_IDX_W = 4;

    // command codes
    localparam logic [2:0] CMD_ACQUIRE     = 3'd0;
    localparam logic [2:0] CMD_RELEASE     = 3'd1;
    localparam logic [2:0] CMD_REMOTE_REQ  = 3'd2;
    localparam logic [2:0] CMD_REMOTE_REL  = 3'd3;
    localparam logic [2:0] CMD_TRY_ACQUIRE = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_ENABLED = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [2:0] ST_NOT_HELD    = 3'd4;
    localparam logic [2:0] ST_BUSY        = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = CFG_IDX_W'(1);

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] lock_key;
        logic [31:0] peer_node;
        logic [31:0] peer_timestamp;
    } t_cmd_word;

    typedef struct packed {
        logic [2:0]  status;
        logic        reply_now;
        logic [31:0] clock_value;
    } t_rsp_word;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [31:0]         owner;
        logic [31:0]         stamp;
        logic                held;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pre;
        logic scan;
        logic apply;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic hit;
        logic miss;
    } t_dp_sts;

endpackage

@@ rtl/core/lock_table_with_lamport_clock.sv @@
// Lock table with a 32-bit Lamport clock; one result word per command word.
// A command is loaded, checked, scanned and applied before o_rsp_valid; the
// key scan (skipped for unknown commands, and for local ones while disabled)
// reads one entry in use (up to 64) per cycle through the table RAM read port.
// Throughput: one command at a time; start is taken again once busy drops.
// Reset (synchronous, i_rst_n low) empties the table, zeroes the clock,
// sets node_id to 1 and clears enabled; the receiver cannot stall results.
module lock_table_with_lamport_clock import ltlc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_cmd_word            i_cmd_word,
    output t_rsp_word            o_rsp_word,
    output logic                 o_rsp_valid,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    ltlc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    ltlc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_word  (i_cmd_word),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_rsp_word  (o_rsp_word),
        .o_rsp_valid (o_rsp_valid)
    );

endmodule

@@ rtl/core/ltlc_ctrl.sv @@
module ltlc_ctrl import ltlc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl,
    output logic    o_busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_ctl.pre = 1'b1;
                n_state   = i_sts.skip ? S_APPLY : S_SCAN;
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.hit || i_sts.miss) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_ctl.apply = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/core/ltlc_dp.sv @@
module ltlc_dp import ltlc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd_word            i_cmd_word,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  t_dp_ctl              i_ctl,
    output t_dp_sts              o_sts,
    output t_rsp_word            o_rsp_word,
    output logic                 o_rsp_valid
);

    localparam logic [IDX_W:0] FILL_MAX = (IDX_W+1)'(ENTRIES);
    localparam logic [IDX_W:0] ONE      = (IDX_W+1)'(1);

    t_entry r_mem [ENTRIES];

    t_cmd_word        r_cmd;
    logic [31:0]      r_node_id;
    logic             r_enabled;
    logic [31:0]      r_clock;
    logic [31:0]      n_clock;
    logic [IDX_W:0]   r_fill;
    logic [IDX_W:0]   r_addr;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    t_entry           r_rdata;
    t_rsp_word        r_rsp;
    logic             r_rsp_valid;

    logic [KEY_BITS-1:0] key_q;
    logic                is_local;
    logic                is_known;
    logic                hit;
    logic                rd_en;
    logic                full;
    logic                owner_is_me;
    logic [31:0]         clk_inc;
    logic [31:0]         remote_clk;
    t_entry              ent;
    logic [IDX_W-1:0]    wr_idx;
    t_entry              wr_data;
    logic                wr_en;
    logic                tick;
    logic [2:0]          n_status;
    logic                n_reply;

    assign key_q    = r_cmd.lock_key[KEY_BITS-1:0];
    assign is_local = (r_cmd.cmd == CMD_ACQUIRE) || (r_cmd.cmd == CMD_RELEASE)
                   || (r_cmd.cmd == CMD_TRY_ACQUIRE);
    assign is_known = is_local || (r_cmd.cmd == CMD_REMOTE_REQ)
                   || (r_cmd.cmd == CMD_REMOTE_REL);

    // entries fill from index zero and are never freed: valid is index < fill
    assign hit   = r_rd_vld && (r_rdata.key == key_q);
    assign rd_en = i_ctl.scan && !hit && (r_addr != r_fill);

    assign o_sts.skip = !is_known || (is_local && !r_enabled);
    assign o_sts.hit  = hit;
    assign o_sts.miss = !hit && (r_addr == r_fill);

    assign full        = !hit && (r_fill == FILL_MAX);
    assign clk_inc     = r_clock + 32'd1;
    assign remote_clk  = ((r_cmd.peer_timestamp > r_clock) ? r_cmd.peer_timestamp : r_clock)
                       + 32'd1;
    assign wr_idx      = hit ? r_rd_idx : r_fill[IDX_W-1:0];
    assign owner_is_me = (ent.owner == r_node_id);

    always_comb begin
        if (hit) begin
            ent = r_rdata;
        end else begin
            ent       = '0;
            ent.key   = key_q;
        end
    end

    always_comb begin
        n_status = ST_OK;
        n_reply  = 1'b0;
        wr_en    = 1'b0;
        wr_data  = ent;
        tick     = 1'b0;
        case (r_cmd.cmd)
            CMD_ACQUIRE: begin
                if (!r_enabled) begin
                    n_status = ST_NOT_ENABLED;
                end else if (full) begin
                    n_status = ST_TABLE_FULL;
                end else begin
                    wr_en = 1'b1;
                    if (!(ent.held && owner_is_me)) begin
                        wr_data.owner = r_node_id;
                        wr_data.stamp = r_clock;
                        wr_data.held  = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                if (!r_enabled) begin
                    n_status = ST_NOT_ENABLED;
                end else if (!hit) begin
                    n_status = ST_NOT_FOUND;
                end else if (!ent.held || !owner_is_me) begin
                    n_status = ST_NOT_HELD;
                end else begin
                    wr_en         = 1'b1;
                    wr_data.owner = '0;
                    wr_data.held  = 1'b0;
                end
            end
            CMD_REMOTE_REQ: begin
                n_reply = !hit || !ent.held
                       || (r_cmd.peer_timestamp < ent.stamp)
                       || ((r_cmd.peer_timestamp == ent.stamp)
                           && (r_cmd.peer_node < r_node_id));
            end
            CMD_REMOTE_REL: begin
                if (hit && (ent.owner == r_cmd.peer_node)) begin
                    wr_en         = 1'b1;
                    wr_data.owner = '0;
                    wr_data.held  = 1'b0;
                end
            end
            CMD_TRY_ACQUIRE: begin
                if (!r_enabled) begin
                    n_status = ST_NOT_ENABLED;
                end else if (full) begin
                    n_status = ST_TABLE_FULL;
                end else if (ent.owner != '0) begin
                    n_status = ST_BUSY;
                end else begin
                    wr_en         = 1'b1;
                    tick          = 1'b1;
                    wr_data.owner = r_node_id;
                    wr_data.stamp = clk_inc;
                    wr_data.held  = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_clock = r_clock;
        if (i_ctl.pre) begin
            if (r_cmd.cmd == CMD_REMOTE_REQ) begin
                n_clock = remote_clk;
            end else if ((r_cmd.cmd == CMD_ACQUIRE) && r_enabled) begin
                n_clock = clk_inc;
            end
        end else if (i_ctl.apply && tick) begin
            n_clock = clk_inc;
        end
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.apply && wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rdata  <= r_mem[r_addr[IDX_W-1:0]];
            r_rd_idx <= r_addr[IDX_W-1:0];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_cmd_word;
        end
        if (i_ctl.apply) begin
            r_rsp.status      <= n_status;
            r_rsp.reply_now   <= n_reply;
            r_rsp.clock_value <= n_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id   <= 32'd1;
            r_enabled   <= 1'b0;
            r_clock     <= '0;
            r_fill      <= '0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_NODE_ID)) begin
                r_node_id <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == CFG_ENABLED)) begin
                r_enabled <= i_cfg_data[0];
            end
            r_clock     <= n_clock;
            r_rsp_valid <= i_ctl.apply;
            if (i_ctl.pre) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
            end else if (rd_en) begin
                r_addr   <= r_addr + ONE;
                r_rd_vld <= 1'b1;
            end else if (i_ctl.scan && !hit) begin
                r_rd_vld <= 1'b0;
            end
            // a write to a fresh entry claims the first free slot
            if (i_ctl.apply && wr_en && !hit) begin
                r_fill <= r_fill + ONE;
            end
        end
    end

    assign o_rsp_word  = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

endmodule

@@ sim/lock_table_checker.sv @@
module lock_table_checker import ltlc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_cmd_word            i_cmd_word,
    input  t_rsp_word            i_rsp_word,
    input  logic                 i_rsp_valid,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_mismatches,
    output int                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    bit                  slot_used  [ENTRIES];
    logic [KEY_BITS-1:0] slot_key   [ENTRIES];
    logic [31:0]         slot_owner [ENTRIES];
    bit                  slot_held  [ENTRIES];
    logic [31:0]         slot_stamp [ENTRIES];
    logic [31:0]         lamport;
    logic [31:0]         my_node;
    logic                local_on;

    t_rsp_word rsp_due[$];
    int        mismatches = 0;

    function automatic int find_slot(input logic [KEY_BITS-1:0] k);
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == k)
                return i;
        end
        return -1;
    endfunction

    // lowest free slot takes an unknown key
    function automatic int claim_slot(input logic [KEY_BITS-1:0] k);
        int s;
        s = find_slot(k);
        if (s >= 0)
            return s;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_used[i]) begin
                slot_used[i]  = 1'b1;
                slot_key[i]   = k;
                slot_owner[i] = '0;
                slot_stamp[i] = '0;
                slot_held[i]  = 1'b0;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_rsp_word lock_result(input t_cmd_word w);
        logic [KEY_BITS-1:0] k;
        int                  s;
        t_rsp_word           r;
        k           = w.lock_key[KEY_BITS-1:0];
        r.status    = ST_OK;
        r.reply_now = 1'b0;
        case (w.cmd)
            CMD_ACQUIRE: begin
                if (!local_on) begin
                    r.status = ST_NOT_ENABLED;
                end else begin
                    // the clock moves even when the table turns out full
                    lamport = lamport + 32'd1;
                    s = claim_slot(k);
                    if (s < 0) begin
                        r.status = ST_TABLE_FULL;
                    end else if (!(slot_held[s] && slot_owner[s] == my_node)) begin
                        slot_owner[s] = my_node;
                        slot_stamp[s] = lamport;
                        slot_held[s]  = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                if (!local_on) begin
                    r.status = ST_NOT_ENABLED;
                end else begin
                    s = find_slot(k);
                    if (s < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else if (!slot_held[s] || slot_owner[s] != my_node) begin
                        r.status = ST_NOT_HELD;
                    end else begin
                        slot_held[s]  = 1'b0;
                        slot_owner[s] = '0;
                    end
                end
            end
            CMD_REMOTE_REQ: begin
                if (w.peer_timestamp > lamport)
                    lamport = w.peer_timestamp;
                lamport = lamport + 32'd1;
                s = find_slot(k);
                // order by timestamp first, then by node
                if (s < 0 || !slot_held[s])
                    r.reply_now = 1'b1;
                else if (w.peer_timestamp < slot_stamp[s])
                    r.reply_now = 1'b1;
                else if (w.peer_timestamp == slot_stamp[s] && w.peer_node < my_node)
                    r.reply_now = 1'b1;
            end
            CMD_REMOTE_REL: begin
                s = find_slot(k);
                if (s >= 0 && slot_owner[s] == w.peer_node) begin
                    slot_owner[s] = '0;
                    slot_held[s]  = 1'b0;
                end
            end
            CMD_TRY_ACQUIRE: begin
                if (!local_on) begin
                    r.status = ST_NOT_ENABLED;
                end else begin
                    s = claim_slot(k);
                    if (s < 0) begin
                        r.status = ST_TABLE_FULL;
                    end else if (slot_owner[s] != '0) begin
                        r.status = ST_BUSY;
                    end else begin
                        slot_owner[s] = my_node;
                        slot_held[s]  = 1'b1;
                        lamport       = lamport + 32'd1;
                        slot_stamp[s] = lamport;
                    end
                end
            end
            default: ;
        endcase
        r.clock_value = lamport;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_held[i] = 1'b0;
            end
            lamport  = '0;
            my_node  = 32'd1;
            local_on = 1'b0;
            rsp_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NODE_ID: my_node  = i_cfg_data;
                    CFG_ENABLED: local_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                rsp_due.push_back(lock_result(i_cmd_word));
            if (i_rsp_valid) begin
                if (rsp_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with no command waiting:", $time,
                             " status %0d reply %0d clock %0h", i_rsp_word.status,
                             i_rsp_word.reply_now, i_rsp_word.clock_value);
                end else begin
                    want = rsp_due.pop_front();
                    if (i_rsp_word.status !== want.status ||
                        i_rsp_word.reply_now !== want.reply_now ||
                        i_rsp_word.clock_value !== want.clock_value) begin
                        mismatches++;
                        $display("%0t: result mismatch:", $time,
                                 " expected status %0d reply %0d clock %0h,",
                                 want.status, want.reply_now, want.clock_value,
                                 " got status %0d reply %0d clock %0h",
                                 i_rsp_word.status, i_rsp_word.reply_now,
                                 i_rsp_word.clock_value);
                    end
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= rsp_due.size();
    end

endmodule

@@ sim/tb_lock_table_with_lamport_clock.sv @@
module tb_lock_table_with_lamport_clock;
    import ltlc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         POOL_SIZE   = 72;
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n   = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    t_cmd_word            cmd_word  = '0;
    t_rsp_word            rsp_word;
    logic                 rsp_valid;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int          mismatches;
    int          outstanding;
    int          cycle_count;
    int          send_idle_pct = 0;
    logic [31:0] cur_node      = 32'd1;
    logic [31:0] last_clock    = '0;
    logic [63:0] key_pool [POOL_SIZE];

    lock_table_with_lamport_clock dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd_word  (cmd_word),
        .o_rsp_word  (rsp_word),
        .o_rsp_valid (rsp_valid),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lock_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_cmd_word    (cmd_word),
        .i_rsp_word    (rsp_word),
        .i_rsp_valid   (rsp_valid),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_lock_table_with_lamport_clock: FAIL");
        $finish;
    end

    // recent clock steers remote timestamps toward the stored stamps
    always @(posedge i_clk) begin
        if (rsp_valid)
            last_clock <= rsp_word.clock_value;
    end

    // start stays high after acceptance; the next word or an idle gap follows
    task automatic issue(input logic [2:0] op, input logic [63:0] key,
                         input logic [31:0] peer, input logic [31:0] ts);
        t_cmd_word w;
        w.cmd            = op;
        w.lock_key       = key;
        w.peer_node      = peer;
        w.peer_timestamp = ts;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        start    <= 1'b1;
        cmd_word <= w;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] node, input logic on);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NODE_ID;
        cfg_data  <= node;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_index <= CFG_ENABLED;
        cfg_data  <= {31'd0, on};
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_node = node;
    endtask

    task automatic issue_random(input int pool_lim);
        logic [2:0]  op;
        logic [63:0] key;
        logic [31:0] peer;
        logic [31:0] ts;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)      op = CMD_ACQUIRE;
        else if (pick < 45) op = CMD_RELEASE;
        else if (pick < 65) op = CMD_REMOTE_REQ;
        else if (pick < 80) op = CMD_REMOTE_REL;
        else if (pick < 95) op = CMD_TRY_ACQUIRE;
        else begin
            case ($urandom_range(0, 2))
                0:       op = CMD_SPARE_A;
                1:       op = CMD_SPARE_B;
                default: op = CMD_SPARE_C;
            endcase
        end
        if ($urandom_range(0, 99) < 8)
            key = {$urandom, $urandom};
        else
            key = key_pool[$urandom_range(0, pool_lim - 1)];
        case ($urandom_range(0, 4))
            0:       peer = cur_node - 32'd1;
            1:       peer = cur_node;
            2:       peer = cur_node + 32'd1;
            3:       peer = '0;
            default: peer = $urandom;
        endcase
        if (op == CMD_REMOTE_REL && $urandom_range(0, 1) == 0)
            peer = cur_node;
        pick = $urandom_range(0, 9);
        if (pick < 6)       ts = last_clock + $urandom_range(0, 4) - 32'd2;
        else if (pick < 8)  ts = $urandom_range(0, 15);
        else if (pick == 8) ts = $urandom;
        else                ts = 32'hFFFF_FFFF - $urandom_range(0, 3);
        issue(op, key, peer, ts);
    endtask

    initial begin
        logic [31:0] node;
        int          pool_lim;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // local commands refused while disabled; remote ones still work
        set_config(32'd1, 1'b0);
        issue(CMD_ACQUIRE, 64'h0123_4567_89AB_CDEF, '0, '0);
        issue(CMD_RELEASE, 64'h0123_4567_89AB_CDEF, '0, '0);
        issue(CMD_TRY_ACQUIRE, 64'h0123_4567_89AB_CDEF, '0, '0);
        issue(CMD_REMOTE_REQ, 64'h0123_4567_89AB_CDEF, '0, '0);
        issue(CMD_REMOTE_REL, 64'h0123_4567_89AB_CDEF, '0, '0);
        issue(CMD_SPARE_A, '1, '1, '1);
        issue(CMD_SPARE_C, '0, '0, '0);

        set_config(32'd1, 1'b1);
        issue(CMD_ACQUIRE, '1, '0, '0);
        issue(CMD_ACQUIRE, '1, '0, '0);
        issue(CMD_TRY_ACQUIRE, '1, '0, '0);
        // lock stamped 2: earlier, tie with lower node, tie with higher, later
        issue(CMD_REMOTE_REQ, '1, 32'd0, 32'd1);
        issue(CMD_REMOTE_REQ, '1, 32'd0, 32'd2);
        issue(CMD_REMOTE_REQ, '1, 32'd2, 32'd2);
        issue(CMD_REMOTE_REQ, '1, 32'd0, 32'd3);
        issue(CMD_RELEASE, '1, '0, '0);
        issue(CMD_RELEASE, '1, '0, '0);
        issue(CMD_RELEASE, '0, '0, '0);
        issue(CMD_TRY_ACQUIRE, '0, '0, '0);
        issue(CMD_REMOTE_REL, '0, 32'd1, '0);
        // clock wraps to zero
        issue(CMD_REMOTE_REQ, '0, '1, '1);

        // a zero node id leaves the owner at zero, so the lock looks free
        set_config(32'd0, 1'b1);
        issue(CMD_TRY_ACQUIRE, 64'h5A5A_A5A5_0F0F_F0F0, '0, '0);
        issue(CMD_TRY_ACQUIRE, 64'h5A5A_A5A5_0F0F_F0F0, '0, '0);
        issue(CMD_REMOTE_REQ, 64'h5A5A_A5A5_0F0F_F0F0, '1, '0);

        set_config(32'hFFFF_FFFF, 1'b1);
        issue(CMD_ACQUIRE, '0, '0, '0);
        issue(CMD_REMOTE_REQ, '0, 32'hFFFF_FFFE, '0);
        issue(CMD_SPARE_B, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        // widen the key pool each phase so the table ends up full
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 87 : 0;
            pool_lim      = (ph == 0) ? 40 : (ph == 1) ? 56 : POOL_SIZE;
            for (int seg = 0; seg < 4; seg++) begin
                case ($urandom_range(0, 5))
                    0:       node = cur_node;
                    1:       node = '0;
                    2:       node = '1;
                    5:       node = $urandom;
                    default: node = $urandom_range(1, 3);
                endcase
                set_config(node, (seg == 0) || ($urandom_range(0, 9) != 0));
                repeat (70) issue_random(pool_lim);
            end
        end

        drain();
        repeat (80) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_lock_table_with_lamport_clock: PASS");
        else
            $display("tb_lock_table_with_lamport_clock: FAIL");
        $finish;
    end

endmodule

@@ lock_table_with_lamport_clock.f @@
rtl/core/ltlc_pkg.sv
rtl/core/ltlc_ctrl.sv
rtl/core/ltlc_dp.sv
rtl/core/lock_table_with_lamport_clock.sv
sim/lock_table_checker.sv
sim/tb_lock_table_with_lamport_clock.sv
